FILE: hdl/srv6_decap_source_nat_macros.svh
// ----------------------------------------------------------------------------
// srv6_decap_source_nat_macros.svh
// Assertion macros for the SRv6 decap source NAT top level.
// Each macro expects aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef SRV6_DECAP_SOURCE_NAT_MACROS_SVH
`define SRV6_DECAP_SOURCE_NAT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define SDN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold on the edge right after a reset edge
`define SDN_ASSERT_AFTER_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !$past(aresetn) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/srv6_dsn_pkg.sv
// ----------------------------------------------------------------------------
// srv6_dsn_pkg
// Types, constants and hash / checksum helpers for the SRv6 decap source NAT.
// ----------------------------------------------------------------------------
package srv6_dsn_pkg;

    // Header match constants
    localparam logic [15:0] ETHER_IPV6 = 16'h86dd;
    localparam logic [7:0]  NH_ROUTING = 8'd43;
    localparam logic [7:0]  SRH_TYPE   = 8'd4;
    localparam logic [7:0]  SRH_LEN    = 8'd2;

    // jhash initial offset: JHASH_INITVAL 0xdeadbeef plus the 8-byte length
    localparam logic [31:0] JH_IV_ADD = 32'hdeadbef7;

    // Register reset values
    localparam logic [31:0] RST_MATCH_SOURCE     = 32'h0a00fe0a;
    localparam logic [31:0] RST_NEW_SOURCE       = 32'h0100008e;
    localparam logic [47:0] RST_LOCAL_SID_PREFIX = 48'hfc0000110001;
    localparam logic [31:0] RST_HASH_SEED        = 32'hdeadbeaf;

    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 2;

    // Pipeline shape: per hash call one IV stage, one load stage, 7 mix stages
    localparam int JH_MIX_STEPS = 7;
    localparam int CALL_STAGES  = JH_MIX_STEPS + 2;
    localparam int HASH_CALLS   = 3;
    localparam int HASH_STAGES  = HASH_CALLS * CALL_STAGES;
    localparam int FIN_STAGES   = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MATCH_SOURCE     = 2'd0,
        CFG_NEW_SOURCE       = 2'd1,
        CFG_LOCAL_SID_PREFIX = 2'd2,
        CFG_HASH_SEED        = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] match_source;
        logic [31:0] new_source;
        logic [47:0] local_sid_prefix;
        logic [31:0] hash_seed;
    } cfg_t;

    // Header fields of one input item
    typedef struct packed {
        logic [15:0] ether_type;
        logic [7:0]  next_header;
        logic [7:0]  route_type;
        logic [7:0]  route_len;
        logic [47:0] outer_dst_prefix;
        logic [31:0] inner_src;
        logic [31:0] inner_dst;
        logic [7:0]  inner_proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] ip_sum_in;
        logic [15:0] tcp_sum_in;
    } hdr_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } jh_t;

    // Words fed into the hash chain
    typedef struct packed {
        logic [31:0] isrc;
        logic [31:0] idst;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
    } words_t;

    // Data riding alongside the hash for the checksum update
    typedef struct packed {
        logic        action;
        logic [15:0] ip_sum;
        logic [15:0] tcp_sum;
        logic [16:0] isrc_sum;
        logic [16:0] ns_sum;
    } side_t;

    typedef struct packed {
        jh_t    st;
        words_t w;
        side_t  s;
    } hp_t;

    typedef struct packed {
        logic        action;
        logic [15:0] port_out;
        logic [15:0] ip_sum_out;
        logic [15:0] tcp_sum_out;
    } res_t;

    function automatic logic [31:0] rotl32(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic int jh_rot(int k);
        int r;
        case (k)
            0:       r = 14;
            1:       r = 11;
            2:       r = 25;
            3:       r = 16;
            4:       r = 4;
            5:       r = 14;
            default: r = 24;
        endcase
        return r;
    endfunction

    // One jhash final-mix step: x ^= y; x -= rotl(y, r)
    function automatic jh_t jh_mix(jh_t s, int k);
        jh_t r;
        r = s;
        case (k)
            0, 3, 6: r.c = (s.c ^ s.b) - rotl32(s.b, jh_rot(k));
            1, 4:    r.a = (s.a ^ s.c) - rotl32(s.c, jh_rot(k));
            default: r.b = (s.b ^ s.a) - rotl32(s.a, jh_rot(k));
        endcase
        return r;
    endfunction

    // One stage of the chained hash; c holds the running seed between calls
    function automatic hp_t hash_step(hp_t d, int call_idx, int sub);
        hp_t r;
        r = d;
        if (sub == 0) begin
            r.st.c = d.st.c + JH_IV_ADD;
            case (call_idx)
                0: begin
                    r.st.a = d.w.isrc;
                    r.st.b = d.w.idst;
                end
                1: begin
                    r.st.a = {16'd0, d.w.sport};
                    r.st.b = {16'd0, d.w.dport};
                end
                default: begin
                    r.st.a = {24'd0, d.w.proto};
                    r.st.b = 32'd0;
                end
            endcase
        end else if (sub == 1) begin
            r.st.a = d.st.a + d.st.c;
            r.st.b = d.st.b + d.st.c;
        end else begin
            r.st = jh_mix(d.st, sub - 2);
        end
        return r;
    endfunction

    // Invert, then one end-around fold if the upper half is non-zero
    function automatic logic [15:0] fold_once(logic [31:0] c);
        logic [31:0] v;
        logic [16:0] s;
        v = ~c;
        s = {1'b0, v[15:0]} + {1'b0, v[31:16]};
        if (v[31:16] != 16'd0) begin
            return s[15:0];
        end else begin
            return v[15:0];
        end
    endfunction

endpackage

FILE: hdl/srv6_decap_source_nat.sv
// ----------------------------------------------------------------------------
// srv6_decap_source_nat
// SRv6 decap source NAT decision: match, port hash and checksum update.
//
// Usage:
//   Input channel s_*: one item holds the header fields of one frame, taken
//   when s_valid and s_ready are both high. Result channel m_*: one item per
//   input item, in order, handed over when m_valid and m_ready are high.
//   m_action is 0 for a passed frame (other fields zero) and 1 for a frame to
//   translate, with the new source port and both updated checksums.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 match source, 1 new source, 2 local SID prefix, 3 hash seed); write
//   only while no item is in flight.
//   Pipeline: 33 register stages (one entry stage, 27 hash stages for three
//   jhash calls of nine stages each, five finish stages). Throughput: one
//   item per cycle while m_ready is high.
//   Reset empties every stage and loads the register defaults; s_ready is
//   high on the first cycle after reset.
//   When m_ready is low, stages fill up behind the held result, bubbles
//   close up, and s_ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
`include "srv6_decap_source_nat_macros.svh"

module srv6_decap_source_nat (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_we,
    input  logic [srv6_dsn_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [srv6_dsn_pkg::CFG_DATA_W-1:0]    cfg_data,
    // header items
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [15:0]                            s_ether_type,
    input  logic [7:0]                             s_next_header,
    input  logic [7:0]                             s_route_type,
    input  logic [7:0]                             s_route_len,
    input  logic [47:0]                            s_outer_dst_prefix,
    input  logic [31:0]                            s_inner_src,
    input  logic [31:0]                            s_inner_dst,
    input  logic [7:0]                             s_inner_proto,
    input  logic [15:0]                            s_src_port,
    input  logic [15:0]                            s_dst_port,
    input  logic [15:0]                            s_ip_sum_in,
    input  logic [15:0]                            s_tcp_sum_in,
    // result items
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_action,
    output logic [15:0]                            m_port_out,
    output logic [15:0]                            m_ip_sum_out,
    output logic [15:0]                            m_tcp_sum_out
);
    import srv6_dsn_pkg::*;

    cfg_t cfg_reg;
    hdr_t hdr;
    hp_t  cls_data;
    hp_t  jh_data;
    res_t res;
    logic cls_valid, cls_ready;
    logic jh_valid, jh_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_source     <= RST_MATCH_SOURCE;
            cfg_reg.new_source       <= RST_NEW_SOURCE;
            cfg_reg.local_sid_prefix <= RST_LOCAL_SID_PREFIX;
            cfg_reg.hash_seed        <= RST_HASH_SEED;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MATCH_SOURCE:     cfg_reg.match_source     <= cfg_data[31:0];
                CFG_NEW_SOURCE:       cfg_reg.new_source       <= cfg_data[31:0];
                CFG_LOCAL_SID_PREFIX: cfg_reg.local_sid_prefix <= cfg_data[47:0];
                CFG_HASH_SEED:        cfg_reg.hash_seed        <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Gather header fields
    always_comb begin
        hdr.ether_type       = s_ether_type;
        hdr.next_header      = s_next_header;
        hdr.route_type       = s_route_type;
        hdr.route_len        = s_route_len;
        hdr.outer_dst_prefix = s_outer_dst_prefix;
        hdr.inner_src        = s_inner_src;
        hdr.inner_dst        = s_inner_dst;
        hdr.inner_proto      = s_inner_proto;
        hdr.src_port         = s_src_port;
        hdr.dst_port         = s_dst_port;
        hdr.ip_sum_in        = s_ip_sum_in;
        hdr.tcp_sum_in       = s_tcp_sum_in;
    end

    srv6_dsn_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_hdr    (hdr),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_data  (cls_data)
    );

    srv6_dsn_jhash u_jhash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_data   (cls_data),
        .out_valid (jh_valid),
        .out_ready (jh_ready),
        .out_data  (jh_data)
    );

    srv6_dsn_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (jh_valid),
        .in_ready  (jh_ready),
        .in_data   (jh_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_action      = res.action;
    assign m_port_out    = res.port_out;
    assign m_ip_sum_out  = res.ip_sum_out;
    assign m_tcp_sum_out = res.tcp_sum_out;

    // Checks
    `SDN_ASSERT_IMP(a_pass_zero, m_valid && !m_action, m_port_out == 16'd0 && m_ip_sum_out == 16'd0 && m_tcp_sum_out == 16'd0, "passed item carries non-zero fields")
    `SDN_ASSERT_IMP(a_port_range, m_valid && m_action, m_port_out != 16'hffff, "port not reduced modulo 0xffff")
    `SDN_ASSERT_IMP(a_full_when_blocked, !s_ready, m_valid && !m_ready, "input blocked with room in the pipeline")
    `SDN_ASSERT_AFTER_RESET(a_empty_after_reset, !m_valid && s_ready, "pipeline not empty after reset")

endmodule

FILE: hdl/srv6_dsn_classify.sv
// ----------------------------------------------------------------------------
// srv6_dsn_classify
// Entry stage: header match decision, hash seed load and checksum pre-sums.
// ----------------------------------------------------------------------------
module srv6_dsn_classify (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  srv6_dsn_pkg::cfg_t   cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  srv6_dsn_pkg::hdr_t   in_hdr,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srv6_dsn_pkg::hp_t    out_data
);
    import srv6_dsn_pkg::*;

    logic valid_reg;
    hp_t  data_reg;
    hp_t  data_next;
    logic match;

    // Translate only SRv6 frames for our SID carrying the watched source
    always_comb begin
        match = (in_hdr.ether_type == ETHER_IPV6) &&
                (in_hdr.next_header == NH_ROUTING) &&
                (in_hdr.route_type == SRH_TYPE) &&
                (in_hdr.route_len == SRH_LEN) &&
                (in_hdr.outer_dst_prefix == cfg.local_sid_prefix) &&
                (in_hdr.inner_src == cfg.match_source);
    end

    // Stage payload
    always_comb begin
        data_next.st.a       = 32'd0;
        data_next.st.b       = 32'd0;
        data_next.st.c       = cfg.hash_seed;
        data_next.w.isrc     = in_hdr.inner_src;
        data_next.w.idst     = in_hdr.inner_dst;
        data_next.w.proto    = in_hdr.inner_proto;
        data_next.w.sport    = in_hdr.src_port;
        data_next.w.dport    = in_hdr.dst_port;
        data_next.s.action   = match;
        data_next.s.ip_sum   = in_hdr.ip_sum_in;
        data_next.s.tcp_sum  = in_hdr.tcp_sum_in;
        data_next.s.isrc_sum = {1'b0, in_hdr.inner_src[15:0]} +
                               {1'b0, in_hdr.inner_src[31:16]};
        data_next.s.ns_sum   = {1'b0, cfg.new_source[15:0]} +
                               {1'b0, cfg.new_source[31:16]};
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/srv6_dsn_jhash.sv
// ----------------------------------------------------------------------------
// srv6_dsn_jhash
// Pipelined chain of three two-word jhash calls, one IV, load or mix step per stage.
// ----------------------------------------------------------------------------
module srv6_dsn_jhash (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  srv6_dsn_pkg::hp_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srv6_dsn_pkg::hp_t    out_data
);
    import srv6_dsn_pkg::*;

    logic valid_reg [HASH_STAGES];
    hp_t  data_reg  [HASH_STAGES];
    wire  [HASH_STAGES:0] rdy;

    assign rdy[HASH_STAGES] = out_ready;

    for (genvar i = 0; i < HASH_STAGES; i++) begin : g_stage
        logic valid_in;
        hp_t  stage_in;
        hp_t  data_next;

        if (i == 0) begin : g_head
            assign valid_in = in_valid;
            assign stage_in = in_data;
        end else begin : g_body
            assign valid_in = valid_reg[i-1];
            assign stage_in = data_reg[i-1];
        end

        // Stage i moves when empty or when the next stage moves
        assign rdy[i]    = ~valid_reg[i] | rdy[i+1];
        assign data_next = hash_step(stage_in, i / CALL_STAGES, i % CALL_STAGES);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                data_reg[i] <= data_next;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[HASH_STAGES-1];
    assign out_data  = data_reg[HASH_STAGES-1];

endmodule

FILE: hdl/srv6_dsn_finish.sv
// ----------------------------------------------------------------------------
// srv6_dsn_finish
// Port reduction modulo 0xffff and incremental IP / TCP checksum update.
// ----------------------------------------------------------------------------
module srv6_dsn_finish (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  srv6_dsn_pkg::hp_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srv6_dsn_pkg::res_t   out_res
);
    import srv6_dsn_pkg::*;

    typedef struct packed {
        logic        action;
        logic [16:0] acc;      // hash half-sum, then the port
        logic [31:0] ip_c;
        logic [31:0] tcp_c;
        logic [16:0] ns_sum;
        logic [15:0] sport;
        logic [15:0] ip_out;
        logic [15:0] tcp_out;
    } fin_t;

    // First stage: fold hash halves, subtract old source from both sums
    function automatic fin_t fin_load(hp_t d);
        fin_t r;
        r         = '0;
        r.action  = d.s.action;
        r.acc     = {1'b0, d.st.c[31:16]} + {1'b0, d.st.c[15:0]};
        r.ip_c    = {16'hffff, ~d.s.ip_sum} - {15'd0, d.s.isrc_sum};
        r.tcp_c   = {16'hffff, ~d.s.tcp_sum} - {15'd0, d.s.isrc_sum};
        r.ns_sum  = d.s.ns_sum;
        r.sport   = d.w.sport;
        return r;
    endfunction

    function automatic fin_t fin_step(fin_t d, int k);
        fin_t        r;
        logic [16:0] t;
        r = d;
        t = {1'b0, d.acc[15:0]} + {16'd0, d.acc[16]};
        case (k)
            1: begin
                // acc <= 0x1fffe, so one more fold fits 16 bits; 0xffff maps to 0
                r.acc   = (t[15:0] == 16'hffff) ? 17'd0 : {1'b0, t[15:0]};
                r.ip_c  = d.ip_c + {15'd0, d.ns_sum};
                r.tcp_c = d.tcp_c - {16'd0, d.sport};
            end
            2: begin
                r.ip_out = fold_once(d.ip_c);
                r.tcp_c  = d.tcp_c + {15'd0, d.ns_sum};
            end
            3: begin
                r.tcp_c = d.tcp_c + {15'd0, d.acc};
            end
            default: begin
                r.tcp_out = fold_once(d.tcp_c);
            end
        endcase
        return r;
    endfunction

    logic valid_reg [FIN_STAGES];
    fin_t data_reg  [FIN_STAGES];
    wire  [FIN_STAGES:0] rdy;
    fin_t fin_last;

    assign rdy[FIN_STAGES] = out_ready;

    for (genvar i = 0; i < FIN_STAGES; i++) begin : g_stage
        logic valid_in;
        fin_t data_next;

        if (i == 0) begin : g_head
            assign valid_in  = in_valid;
            assign data_next = fin_load(in_data);
        end else begin : g_body
            assign valid_in  = valid_reg[i-1];
            assign data_next = fin_step(data_reg[i-1], i);
        end

        assign rdy[i] = ~valid_reg[i] | rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                data_reg[i] <= data_next;
            end
        end
    end

    // Passed frames report zero in all numeric fields
    assign fin_last = data_reg[FIN_STAGES-1];
    always_comb begin
        out_res.action      = fin_last.action;
        out_res.port_out    = fin_last.action ? fin_last.acc[15:0] : 16'd0;
        out_res.ip_sum_out  = fin_last.action ? fin_last.ip_out : 16'd0;
        out_res.tcp_sum_out = fin_last.action ? fin_last.tcp_out : 16'd0;
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[FIN_STAGES-1];

endmodule
